@@ rtl/pat_pkg.sv @@
package pat_pkg;

  localparam int DEPTH   = 64;
  localparam int OP_W    = 2;
  localparam int POS_W   = 7;
  localparam int VAL_W   = 32;
  localparam int STAT_W  = 2;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_UPDATE = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE      = 2'd0,
    ST_INVALID   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CMD_INSERT,
    CMD_DELETE,
    CMD_UPDATE,
    CMD_SEARCH,
    CMD_REPLY
  } cmd_kind_t;

  typedef enum logic {
    BK_IDLE,
    BK_SCAN
  } back_state_t;

  typedef struct packed {
    cmd_kind_t                kind;
    logic [IDX_W-1:0]         idx;
    logic signed [VAL_W-1:0]  value;
    status_t                  status;
    logic [CNT_W-1:0]         count;
  } cmd_t;

endpackage

@@ rtl/pat_if.sv @@
interface pat_in_if;
  import pat_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output op, output position, output value, input ready);
  modport sink (input valid, input op, input position, input value, output ready);
endinterface

interface pat_out_if;
  import pat_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [POS_W-1:0]  match_position;
  logic [POS_W-1:0]  entry_count;
  logic              last;

  modport source (output valid, output status, output match_position, output entry_count,
                  output last, input ready);
  modport sink (input valid, input status, input match_position, input entry_count,
                input last, output ready);
endinterface

@@ rtl/pat_front.sv @@
module pat_front (
  input  logic           clk,
  input  logic           rst_n,
  pat_in_if.sink         in_ch,
  input  logic           q_full,
  output logic           q_wr,
  output pat_pkg::cmd_t  q_wr_data
);
  import pat_pkg::*;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [POS_W-1:0] cnt_ext;
  logic             pos_zero;

  assign in_ch.ready = !q_full;
  assign q_wr        = in_ch.valid && !q_full;
  assign cnt_ext     = POS_W'(cnt_r);
  assign pos_zero    = (in_ch.position == '0);

  // shadow count: range and full checks are decided here, and the count travels with each command to the back end
  always_comb begin
    cnt_nxt          = cnt_r;
    q_wr_data.kind   = CMD_REPLY;
    q_wr_data.idx    = IDX_W'(in_ch.position - POS_W'(1));
    q_wr_data.value  = in_ch.value;
    q_wr_data.status = ST_DONE;
    unique case (op_t'(in_ch.op))
      OP_INSERT: begin
        if (pos_zero || in_ch.position > cnt_ext + POS_W'(1)) begin
          q_wr_data.status = ST_INVALID;
        end else if (cnt_r == CNT_W'(DEPTH)) begin
          q_wr_data.status = ST_FULL;
        end else begin
          q_wr_data.kind = CMD_INSERT;
          cnt_nxt        = cnt_r + CNT_W'(1);
        end
      end
      OP_DELETE: begin
        if (pos_zero || in_ch.position > cnt_ext) begin
          q_wr_data.status = ST_INVALID;
        end else begin
          q_wr_data.kind = CMD_DELETE;
          cnt_nxt        = cnt_r - CNT_W'(1);
        end
      end
      OP_UPDATE: begin
        if (pos_zero || in_ch.position > cnt_ext) begin
          q_wr_data.status = ST_INVALID;
        end else begin
          q_wr_data.kind = CMD_UPDATE;
        end
      end
      OP_SEARCH: begin
        q_wr_data.kind = CMD_SEARCH;
      end
      default: ;
    endcase
    q_wr_data.count = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (q_wr) begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ rtl/pat_queue.sv @@
module pat_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr,
  input  pat_pkg::cmd_t  wr_data,
  output logic           full,
  input  logic           rd,
  output pat_pkg::cmd_t  rd_data,
  output logic           empty
);
  import pat_pkg::*;

  cmd_t               slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wp_r, rp_r;
  logic [Q_CNT_W-1:0] fill_r;

  assign full    = (fill_r == Q_CNT_W'(Q_DEPTH));
  assign empty   = (fill_r == '0);
  assign rd_data = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr) begin
      slot_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      fill_r <= '0;
    end else begin
      if (wr) begin
        wp_r <= wp_r + Q_PTR_W'(1);
      end
      if (rd) begin
        rp_r <= rp_r + Q_PTR_W'(1);
      end
      if (wr && !rd) begin
        fill_r <= fill_r + Q_CNT_W'(1);
      end else if (rd && !wr) begin
        fill_r <= fill_r - Q_CNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/pat_back.sv @@
module pat_back (
  input  logic           clk,
  input  logic           rst_n,
  input  pat_pkg::cmd_t  cmd,
  input  logic           q_empty,
  output logic           q_rd,
  pat_out_if.source      out_ch
);
  import pat_pkg::*;

  back_state_t state_r, state_nxt;

  logic signed [VAL_W-1:0] cells_r [DEPTH];
  logic [DEPTH-1:0]        match_vec, match_r, match_rest;
  logic [IDX_W-1:0]        idx_r;
  logic [CNT_W-1:0]        scnt_r;

  logic              out_valid_r;
  status_t           out_status_r;
  logic [POS_W-1:0]  out_mpos_r;
  logic [POS_W-1:0]  out_cnt_r;
  logic              out_last_r;

  logic             can_emit, emit, ld_match, adv, cell_we;
  status_t          e_status;
  logic [POS_W-1:0] e_mpos;
  logic [POS_W-1:0] e_cnt;
  logic             e_last;

  assign can_emit   = !out_valid_r || out_ch.ready;
  assign match_rest = match_r & ~(DEPTH'(1) << idx_r);

  // shifting cell chain and per-cell key compare
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [VAL_W-1:0] below, above;
    if (g == 0) begin : g_bot
      assign below = cells_r[g];
    end else begin : g_mid_b
      assign below = cells_r[g-1];
    end
    if (g == DEPTH - 1) begin : g_top
      assign above = cells_r[g];
    end else begin : g_mid_a
      assign above = cells_r[g+1];
    end

    assign match_vec[g] = (cells_r[g] == cmd.value) && (CNT_W'(g) < cmd.count);

    always_ff @(posedge clk) begin
      if (cell_we) begin
        unique case (cmd.kind)
          CMD_INSERT: begin
            if (IDX_W'(g) == cmd.idx) begin
              cells_r[g] <= cmd.value;
            end else if (IDX_W'(g) > cmd.idx) begin
              cells_r[g] <= below;
            end
          end
          CMD_DELETE: begin
            if (IDX_W'(g) >= cmd.idx) begin
              cells_r[g] <= above;
            end
          end
          CMD_UPDATE: begin
            if (IDX_W'(g) == cmd.idx) begin
              cells_r[g] <= cmd.value;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    q_rd     = 1'b0;
    emit     = 1'b0;
    ld_match = 1'b0;
    adv      = 1'b0;
    cell_we  = 1'b0;
    e_status = ST_DONE;
    e_mpos   = '0;
    e_cnt    = POS_W'(scnt_r);
    e_last   = 1'b1;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          if (cmd.kind == CMD_SEARCH) begin
            q_rd     = 1'b1;
            ld_match = 1'b1;
          end else if (can_emit) begin
            q_rd     = 1'b1;
            emit     = 1'b1;
            cell_we  = 1'b1;
            e_status = cmd.status;
            e_cnt    = POS_W'(cmd.count);
          end
        end
      end
      BK_SCAN: begin
        if (match_r == '0) begin
          emit     = can_emit;
          e_status = ST_NOT_FOUND;
        end else if (match_r[idx_r]) begin
          emit   = can_emit;
          adv    = can_emit;
          e_mpos = POS_W'(idx_r) + POS_W'(1);
          e_last = (match_rest == '0);
        end else begin
          adv = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (ld_match) begin
          state_nxt = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (emit && e_last) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_status_r <= e_status;
      out_mpos_r   <= e_mpos;
      out_cnt_r    <= e_cnt;
      out_last_r   <= e_last;
    end
    if (ld_match) begin
      match_r <= match_vec;
      idx_r   <= '0;
      scnt_r  <= cmd.count;
    end else if (adv) begin
      match_r <= match_rest;
      idx_r   <= idx_r + IDX_W'(1);
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.match_position = out_mpos_r;
  assign out_ch.entry_count    = out_cnt_r;
  assign out_ch.last           = out_last_r;

endmodule

@@ rtl/positional_array_table_core.sv @@
// A result is valid on the output once its word has passed the queue and then the output
// register.
// Insert, delete, update and out-of-range words: one per cycle unless the output stalls,
// one result each. Search: all cells are compared at once and the matches registered, then
// positions are scanned in order up to the last match (one result per match), or a single
// not-found result is given; the back end takes no other word during the scan.
// Reset (rst_n low, synchronous): entry count, queue and output valid clear; cell contents
// are left as they are and are only read after they are written.
module positional_array_table_core (
  input  logic      clk,
  input  logic      rst_n,
  pat_in_if.sink    in_ch,
  pat_out_if.source out_ch
);
  import pat_pkg::*;

  cmd_t wr_data, rd_data;
  logic q_wr, q_rd, q_full, q_empty;

  pat_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .q_wr      (q_wr),
    .q_wr_data (wr_data)
  );

  pat_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .wr_data (wr_data),
    .full    (q_full),
    .rd      (q_rd),
    .rd_data (rd_data),
    .empty   (q_empty)
  );

  pat_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (rd_data),
    .q_empty (q_empty),
    .q_rd    (q_rd),
    .out_ch  (out_ch)
  );

endmodule

@@ rtl/pat_checker.sv @@
module pat_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [pat_pkg::STAT_W-1:0] out_status,
  input logic [pat_pkg::POS_W-1:0]  out_match_position,
  input logic [pat_pkg::POS_W-1:0]  out_entry_count,
  input logic                       out_last
);
  import pat_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
    $stable(out_match_position) && $stable(out_entry_count) && $stable(out_last))
    else $error("output word changed while stalled");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_count <= POS_W'(DEPTH))
    else $error("entry count above depth");

  a_match_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_match_position != '0 |->
    out_status == ST_DONE && out_match_position <= out_entry_count)
    else $error("match position outside list");

  a_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_status == ST_DONE && out_match_position != '0)
    else $error("non-final result is not a search match");

endmodule

bind positional_array_table_core pat_checker u_pat_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_status         (out_ch.status),
  .out_match_position (out_ch.match_position),
  .out_entry_count    (out_ch.entry_count),
  .out_last           (out_ch.last)
);

@@ tb/tb.sv @@
module tb;
  import pat_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 250;

  typedef struct {
    op_t                     op;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] val;
  } table_op_t;

  typedef struct {
    status_t          status;
    logic [POS_W-1:0] mpos;
    logic [POS_W-1:0] count;
    logic             last;
  } table_reply_t;

  typedef enum int {
    BIAS_GROW,
    BIAS_SHRINK,
    BIAS_MIXED
  } bias_t;

  logic clk;
  logic rst_n;

  pat_in_if  in_ch ();
  pat_out_if out_ch ();

  positional_array_table_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  table_op_t    op_queue[$];
  table_reply_t pending_replies[$];

  logic signed [VAL_W-1:0] tbl_vals [DEPTH];
  int tbl_cnt;
  int plan_cnt;
  int peak_cnt;
  int op_tally [4];
  int st_tally [4];

  int n_in;
  int n_out;
  int fails;
  int send_gap;
  int recv_gap;
  int hold_left;
  bit hold_done;
  int quiet_cycles;
  table_op_t nxt;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int pick_gap(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh0000_0000;
      1: return -32'sd1;
      2: return 32'sh8000_0000;
      3: return 32'sh7fff_ffff;
      4: return 32'sd7;
      5: return 32'sh5555_5555;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_reply(input status_t st, input int mpos, input bit last);
    table_reply_t r;
    r.status = st;
    r.mpos   = mpos[POS_W-1:0];
    r.count  = tbl_cnt[POS_W-1:0];
    r.last   = last;
    st_tally[st]++;
    pending_replies.push_back(r);
  endtask

  // shadow list: shift, overwrite and scan, one expected reply per match
  task automatic apply_table_op(input op_t op, input int pos, input logic signed [VAL_W-1:0] val);
    int i;
    int hits;
    int k;
    op_tally[op]++;
    case (op)
      OP_INSERT: begin
        if (pos < 1 || pos > tbl_cnt + 1) begin
          push_reply(ST_INVALID, 0, 1'b1);
        end else if (tbl_cnt >= DEPTH) begin
          push_reply(ST_FULL, 0, 1'b1);
        end else begin
          for (i = tbl_cnt; i >= pos; i--) tbl_vals[i] = tbl_vals[i-1];
          tbl_vals[pos-1] = val;
          tbl_cnt++;
          if (tbl_cnt > peak_cnt) peak_cnt = tbl_cnt;
          push_reply(ST_DONE, 0, 1'b1);
        end
      end
      OP_DELETE: begin
        if (pos < 1 || pos > tbl_cnt) begin
          push_reply(ST_INVALID, 0, 1'b1);
        end else begin
          for (i = pos; i < tbl_cnt; i++) tbl_vals[i-1] = tbl_vals[i];
          tbl_cnt--;
          push_reply(ST_DONE, 0, 1'b1);
        end
      end
      OP_UPDATE: begin
        if (pos < 1 || pos > tbl_cnt) begin
          push_reply(ST_INVALID, 0, 1'b1);
        end else begin
          tbl_vals[pos-1] = val;
          push_reply(ST_DONE, 0, 1'b1);
        end
      end
      default: begin
        hits = 0;
        for (i = 0; i < tbl_cnt; i++) if (tbl_vals[i] == val) hits++;
        if (hits == 0) begin
          push_reply(ST_NOT_FOUND, 0, 1'b1);
        end else begin
          k = 0;
          for (i = 0; i < tbl_cnt; i++) begin
            if (tbl_vals[i] == val) begin
              k++;
              push_reply(ST_DONE, i + 1, k == hits);
            end
          end
        end
      end
    endcase
  endtask

  task automatic queue_op(input op_t op, input int pos, input logic signed [VAL_W-1:0] val);
    table_op_t t;
    t.op  = op;
    t.pos = pos[POS_W-1:0];
    t.val = val;
    op_queue.push_back(t);
    if (op == OP_INSERT && pos >= 1 && pos <= plan_cnt + 1 && plan_cnt < DEPTH) plan_cnt++;
    if (op == OP_DELETE && pos >= 1 && pos <= plan_cnt) plan_cnt--;
  endtask

  task automatic queue_random_op(input bias_t bias);
    int r;
    int t_ins;
    int t_del;
    r = $urandom_range(0, 99);
    case (bias)
      BIAS_GROW:   begin t_ins = 55; t_del = 70; end
      BIAS_SHRINK: begin t_ins = 20; t_del = 70; end
      default:     begin t_ins = 35; t_del = 60; end
    endcase
    if (r < 6) begin
      queue_op(op_t'($urandom_range(0, 3)), $urandom_range(0, 127), $urandom);
    end else if (r < t_ins) begin
      queue_op(OP_INSERT, $urandom_range(1, plan_cnt + 1), pick_value());
    end else if (r < t_del) begin
      queue_op(OP_DELETE, plan_cnt == 0 ? $urandom_range(0, 1) : $urandom_range(1, plan_cnt),
               pick_value());
    end else if (r < 85) begin
      queue_op(OP_SEARCH, $urandom_range(0, 127), pick_value());
    end else begin
      queue_op(OP_UPDATE, plan_cnt == 0 ? $urandom_range(0, 1) : $urandom_range(1, plan_cnt),
               pick_value());
    end
  endtask

  task automatic check_reply();
    table_reply_t e;
    n_out++;
    if (pending_replies.size() == 0) begin
      fails++;
      $display("%0t: unexpected word status %0d mpos %0d count %0d last %0d", $time,
               out_ch.status, out_ch.match_position, out_ch.entry_count, out_ch.last);
    end else begin
      e = pending_replies.pop_front();
      if (out_ch.status !== e.status || out_ch.match_position !== e.mpos ||
          out_ch.entry_count !== e.count || out_ch.last !== e.last) begin
        fails++;
        $display("%0t: mismatch expected status %0d mpos %0d count %0d last %0d", $time,
                 e.status, e.mpos, e.count, e.last);
        $display("%0t:          actual   status %0d mpos %0d count %0d last %0d", $time,
                 out_ch.status, out_ch.match_position, out_ch.entry_count, out_ch.last);
      end
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        apply_table_op(op_t'(in_ch.op), in_ch.position, in_ch.value);
        n_in++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0 && hold_left == 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (op_queue.size() > 0) begin
          nxt = op_queue.pop_front();
          in_ch.valid    <= 1'b1;
          in_ch.op       <= nxt.op;
          in_ch.position <= nxt.pos;
          in_ch.value    <= nxt.val;
          send_gap = pick_gap((n_in / 40) % 4 == 3);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left <= 0;
      recv_gap = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_reply();
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else if (!hold_done && n_out >= 60) begin
        hold_done = 1'b1;
        hold_left <= HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        recv_gap = pick_gap((n_out / 50) % 4 == 1);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles = 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
        $display("positional_array_table_core regression: fail");
        $finish;
      end
    end
  end

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.op       = '0;
    in_ch.position = '0;
    in_ch.value    = '0;
    out_ch.ready   = 1'b0;
    tbl_cnt  = 0;
    plan_cnt = 0;
    peak_cnt = 0;
    n_in     = 0;
    n_out    = 0;
    fails    = 0;
    hold_left = 0;
    hold_done = 1'b0;
    foreach (op_tally[i]) op_tally[i] = 0;
    foreach (st_tally[i]) st_tally[i] = 0;

    // empty list, out-of-range positions
    queue_op(OP_SEARCH, 0, 32'sd0);
    queue_op(OP_INSERT, 0, 32'sd1);
    queue_op(OP_INSERT, 2, 32'sd1);
    queue_op(OP_DELETE, 1, 32'sd0);
    queue_op(OP_UPDATE, 1, 32'sd5);
    queue_op(OP_DELETE, 0, 32'sd0);
    // build 0, -1, min, max, -1
    queue_op(OP_INSERT, 1, 32'sh8000_0000);
    queue_op(OP_INSERT, 2, 32'sh7fff_ffff);
    queue_op(OP_INSERT, 1, 32'sd0);
    queue_op(OP_INSERT, 2, -32'sd1);
    queue_op(OP_INSERT, 5, -32'sd1);
    queue_op(OP_SEARCH, 127, -32'sd1);
    queue_op(OP_SEARCH, 0, 32'sh8000_0000);
    queue_op(OP_SEARCH, 3, 32'sd12345);
    queue_op(OP_UPDATE, 0, 32'sd9);
    queue_op(OP_UPDATE, 6, 32'sd9);
    queue_op(OP_UPDATE, 3, 32'sd0);
    queue_op(OP_SEARCH, 64, 32'sd0);
    queue_op(OP_INSERT, 7, 32'sd2);
    queue_op(OP_INSERT, 127, 32'sd2);
    queue_op(OP_DELETE, 6, 32'sd0);
    queue_op(OP_DELETE, 1, 32'sd0);
    queue_op(OP_DELETE, 4, 32'sd0);
    queue_op(OP_DELETE, 127, 32'sd0);
    queue_op(OP_UPDATE, 64, 32'sd0);

    // fill to capacity with one key, then the full-store cases
    while (plan_cnt < DEPTH) queue_op(OP_INSERT, $urandom_range(1, plan_cnt + 1), 32'sd7);
    queue_op(OP_INSERT, DEPTH + 1, 32'sd1);
    queue_op(OP_INSERT, 1, 32'sd1);
    queue_op(OP_INSERT, DEPTH + 2, 32'sd1);
    queue_op(OP_SEARCH, 0, 32'sd7);
    queue_op(OP_UPDATE, DEPTH, -32'sd1);
    queue_op(OP_SEARCH, 0, -32'sd1);
    queue_op(OP_DELETE, DEPTH, 32'sd0);
    queue_op(OP_INSERT, DEPTH, 32'sd3);
    queue_op(OP_UPDATE, 1, 32'sh8000_0000);

    for (int i = 0; i < 30; i++) queue_random_op(BIAS_SHRINK);
    for (int i = 0; i < 30; i++) queue_random_op(BIAS_SHRINK);
    for (int i = 0; i < 30; i++) queue_random_op(BIAS_GROW);
    for (int i = 0; i < 30; i++) queue_random_op(BIAS_MIXED);
    while (plan_cnt > 0) begin
      if ($urandom_range(0, 3) == 0) queue_op(OP_SEARCH, 0, pick_value());
      queue_op(OP_DELETE, $urandom_range(1, plan_cnt), 32'sd0);
    end
    queue_op(OP_SEARCH, 0, 32'sd7);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (op_queue.size() != 0 || in_ch.valid || pending_replies.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d operations (insert %0d, delete %0d, search %0d, update %0d), %0d words",
             n_in, op_tally[OP_INSERT], op_tally[OP_DELETE], op_tally[OP_SEARCH],
             op_tally[OP_UPDATE], n_out);
    $display("peak count %0d; done %0d, invalid %0d, full %0d, not found %0d; %0d errors",
             peak_cnt, st_tally[ST_DONE], st_tally[ST_INVALID], st_tally[ST_FULL],
             st_tally[ST_NOT_FOUND], fails);
    if (fails == 0) begin
      $display("positional_array_table_core regression: pass");
    end else begin
      $display("positional_array_table_core regression: fail");
    end
    $finish;
  end

endmodule
